// ----- design/rts_pkg.sv -----
package rts_pkg;

    localparam int KEY_W = 64;
    localparam int PRIO_W = 4;
    localparam int CNT_W = 9;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_SORT_NAME = 3'd3;
    localparam logic [2:0] CMD_SORT_TYPE = 3'd4;
    localparam logic [2:0] CMD_SORT_PRIO = 3'd5;
    localparam logic [2:0] CMD_READ = 3'd6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_BAD_PRIO = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;
    localparam logic [2:0] ST_NOT_SORTED = 3'd6;

    localparam logic [3:0] PRIO_MIN = 4'd1;
    localparam logic [3:0] PRIO_MAX = 4'd10;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] name_key;
        logic [63:0] type_key;
        logic [3:0]  priority_in;
        logic [4:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  position;
        logic [8:0]  compare_count;
        logic [8:0]  swap_count;
        logic [63:0] entry_name;
        logic [63:0] entry_type;
        logic [3:0]  entry_priority;
        logic [5:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  name;
        logic [KEY_W-1:0]  kind;
        logic [PRIO_W-1:0] prio;
    } t_rec;

endpackage

// ----- design/rts_ram.sv -----
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/rts_datapath.sv -----
module rts_datapath
    import rts_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int AW = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  t_rec             i_wdata,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_hold_a,
    output t_rec             o_rdata,
    output t_rec             o_reg_a
);
    logic [$bits(t_rec)-1:0] w_rdata;
    t_rec r_a;

    rts_ram #(.WIDTH($bits(t_rec)), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_hold_a) begin
            r_a <= t_rec'(w_rdata);
        end
    end

    assign o_rdata = t_rec'(w_rdata);
    assign o_reg_a = r_a;
endmodule

// ----- design/rts_ctrl.sv -----
module rts_ctrl
    import rts_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BYTES = 8,
    parameter int AW = 5,
    parameter int FW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output t_rsp          o_rsp,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_rec          o_wdata,
    output logic [AW-1:0] o_raddr,
    output logic          o_hold_a,
    input  t_rec          i_rdata,
    input  t_rec          i_reg_a
);
    localparam logic [KEY_W-1:0] KEY_MASK = ~64'd0 << (8 * (8 - KEY_BYTES));
    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RM_RD = 4'd1;
    localparam logic [3:0] S_RM_CHK = 4'd2;
    localparam logic [3:0] S_RM_SH = 4'd3;
    localparam logic [3:0] S_SR_RD = 4'd4;
    localparam logic [3:0] S_SR_CHK = 4'd5;
    localparam logic [3:0] S_BS_RD = 4'd6;
    localparam logic [3:0] S_BS_CHK = 4'd7;
    localparam logic [3:0] S_IS_RD = 4'd8;
    localparam logic [3:0] S_IS_CHK = 4'd9;
    localparam logic [3:0] S_SS_RD = 4'd10;
    localparam logic [3:0] S_SS_CHK = 4'd11;
    localparam logic [3:0] S_SS_SW = 4'd12;
    localparam logic [3:0] S_RD = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;
    localparam logic [3:0] S_WB = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_sorted, n_sorted;
    t_req          r_req, n_req;
    t_rsp          r_rsp, n_rsp;
    logic          r_ovalid, n_ovalid;
    logic [FW-1:0] r_i, n_i, r_j, n_j, r_m, n_m;
    logic [FW:0]   r_lo, n_lo, r_hi, n_hi;
    logic [9:0]    r_cmp, n_cmp, r_sw, n_sw;
    logic          r_phase, n_phase;
    t_rec          r_key, n_key;
    logic [FW:0]   w_mid;
    logic [FW-1:0] w_ri;
    logic [KEY_W-1:0] w_nk;

    assign o_req_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp = r_rsp;
    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_ri = FW'(i_req.read_index);
    assign w_nk = r_req.name_key & KEY_MASK;

    function automatic logic [8:0] sat9(input logic [9:0] v);
        sat9 = v[9] ? 9'h1ff : v[8:0];
    endfunction

    // counters stop once past the 9-bit range
    function automatic logic [9:0] cnt_inc(input logic [9:0] v);
        cnt_inc = v[9] ? v : v + 10'd1;
    endfunction

    always_comb begin
        n_state = r_state;
        n_fill = r_fill;
        n_sorted = r_sorted;
        n_req = r_req;
        n_rsp = r_rsp;
        n_ovalid = r_ovalid;
        n_i = r_i;
        n_j = r_j;
        n_m = r_m;
        n_lo = r_lo;
        n_hi = r_hi;
        n_cmp = r_cmp;
        n_sw = r_sw;
        n_phase = r_phase;
        n_key = r_key;
        o_we = 1'b0;
        o_waddr = '0;
        o_wdata = r_key;
        o_raddr = '0;
        o_hold_a = 1'b0;
        if (r_ovalid && i_rsp_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_cmp = '0;
                    n_sw = '0;
                    n_state = S_DONE;
                    case (i_req.command)
                        CMD_APPEND: begin
                            n_sorted = 1'b0;
                            if (r_fill >= CAP_F) begin
                                n_rsp.status = ST_FULL;
                            end else if (i_req.priority_in < PRIO_MIN ||
                                         i_req.priority_in > PRIO_MAX) begin
                                n_rsp.status = ST_BAD_PRIO;
                            end else begin
                                o_we = 1'b1;
                                o_waddr = AW'(r_fill);
                                o_wdata.name = i_req.name_key & KEY_MASK;
                                o_wdata.kind = i_req.type_key & KEY_MASK;
                                o_wdata.prio = i_req.priority_in;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            n_sorted = 1'b0;
                            n_rsp.status = ST_NOT_FOUND;
                            n_i = '0;
                            n_state = S_RM_RD;
                        end
                        CMD_SEARCH: begin
                            if (!r_sorted) begin
                                n_rsp.status = ST_NOT_SORTED;
                            end else if (r_fill == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_rsp.status = ST_NOT_FOUND;
                                n_lo = '0;
                                n_hi = {1'b0, r_fill} - 1'b1;
                                n_state = S_SR_RD;
                            end
                        end
                        CMD_SORT_NAME: begin
                            n_sorted = 1'b1;
                            if (r_fill == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_i = '0;
                                n_j = '0;
                                n_state = S_BS_RD;
                            end
                        end
                        CMD_SORT_TYPE: begin
                            n_sorted = 1'b0;
                            n_i = FW'(1);
                            n_phase = 1'b0;
                            n_state = S_IS_RD;
                        end
                        CMD_SORT_PRIO: begin
                            n_sorted = 1'b0;
                            n_i = '0;
                            n_phase = 1'b0;
                            n_state = S_SS_RD;
                        end
                        CMD_READ: begin
                            if (w_ri >= r_fill) begin
                                n_rsp.status = ST_BAD_INDEX;
                            end else begin
                                o_raddr = AW'(i_req.read_index);
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                n_rsp.entry_name = i_rdata.name;
                n_rsp.entry_type = i_rdata.kind;
                n_rsp.entry_priority = i_rdata.prio;
                n_state = S_DONE;
            end
            S_RM_RD: begin
                if (r_i >= r_fill) begin
                    n_state = S_DONE;
                end else begin
                    o_raddr = AW'(r_i);
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (i_rdata.name == w_nk) begin
                    n_rsp.status = ST_OK;
                    n_rsp.position = 5'(r_i);
                    n_j = r_i;
                    n_state = S_RM_SH;
                    n_phase = 1'b0;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_RM_RD;
                end
            end
            S_RM_SH: begin
                if (!r_phase) begin
                    if (r_j + 1'b1 >= r_fill) begin
                        n_fill = r_fill - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_raddr = AW'(r_j + 1'b1);
                        n_phase = 1'b1;
                    end
                end else begin
                    o_we = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = i_rdata;
                    n_j = r_j + 1'b1;
                    n_phase = 1'b0;
                end
            end
            S_SR_RD: begin
                if (r_lo > r_hi || r_hi[FW]) begin
                    n_state = S_DONE;
                end else begin
                    o_raddr = AW'(w_mid);
                    n_state = S_SR_CHK;
                end
            end
            S_SR_CHK: begin
                n_cmp = cnt_inc(r_cmp);
                if (i_rdata.name == w_nk) begin
                    n_rsp.status = ST_OK;
                    n_rsp.position = 5'(w_mid);
                    n_rsp.entry_name = i_rdata.name;
                    n_rsp.entry_type = i_rdata.kind;
                    n_rsp.entry_priority = i_rdata.prio;
                    n_state = S_DONE;
                end else begin
                    if (w_nk < i_rdata.name) begin
                        n_hi = w_mid - 1'b1;
                    end else begin
                        n_lo = w_mid + 1'b1;
                    end
                    n_state = S_SR_RD;
                end
            end
            S_BS_RD: begin
                if (r_i + 1'b1 >= r_fill) begin
                    n_state = S_DONE;
                end else if (!r_phase) begin
                    o_raddr = AW'(r_j);
                    o_hold_a = 1'b0;
                    n_phase = 1'b1;
                end else begin
                    o_raddr = AW'(r_j + 1'b1);
                    o_hold_a = 1'b1;
                    n_phase = 1'b0;
                    n_state = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                n_cmp = cnt_inc(r_cmp);
                if (!r_phase && i_reg_a.name > i_rdata.name) begin
                    o_we = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = i_rdata;
                    n_key = i_reg_a;
                    n_sw = cnt_inc(r_sw);
                    n_state = S_WB;
                    n_m = r_j + 1'b1;
                end else begin
                    n_state = S_BS_RD;
                end
                if (r_j + 2'd2 >= r_fill - r_i) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_WB: begin
                o_we = 1'b1;
                o_waddr = AW'(r_m);
                o_wdata = r_key;
                n_state = (r_req.command == CMD_SORT_NAME) ? S_BS_RD : S_SS_RD;
                if (r_req.command == CMD_SORT_PRIO) begin
                    n_i = r_i + 1'b1;
                end
            end
            S_IS_RD: begin
                if (r_i >= r_fill) begin
                    n_state = S_DONE;
                end else if (!r_phase) begin
                    o_raddr = AW'(r_i);
                    n_phase = 1'b1;
                end else begin
                    n_key = i_rdata;
                    n_j = r_i;
                    o_raddr = AW'(r_i - 1'b1);
                    n_phase = 1'b0;
                    n_state = S_IS_CHK;
                end
            end
            S_IS_CHK: begin
                if (r_j != '0 && i_rdata.kind > r_key.kind) begin
                    o_we = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = i_rdata;
                    n_cmp = cnt_inc(r_cmp);
                    n_sw = cnt_inc(r_sw);
                    n_j = r_j - 1'b1;
                    o_raddr = AW'(r_j - 2'd2);
                end else begin
                    o_we = 1'b1;
                    o_waddr = AW'(r_j);
                    o_wdata = r_key;
                    n_i = r_i + 1'b1;
                    n_state = S_IS_RD;
                end
            end
            S_SS_RD: begin
                if (r_i + 1'b1 >= r_fill) begin
                    n_state = S_DONE;
                end else if (!r_phase) begin
                    o_raddr = AW'(r_i);
                    n_phase = 1'b1;
                end else begin
                    n_key = i_rdata;
                    o_hold_a = 1'b1;
                    n_m = r_i;
                    n_j = r_i + 1'b1;
                    o_raddr = AW'(r_i + 1'b1);
                    n_phase = 1'b0;
                    n_state = S_SS_CHK;
                end
            end
            S_SS_CHK: begin
                n_cmp = cnt_inc(r_cmp);
                if (i_rdata.prio < r_key.prio) begin
                    n_key = i_rdata;
                    n_m = r_j;
                end
                if (r_j + 1'b1 >= r_fill) begin
                    n_state = S_SS_SW;
                end else begin
                    n_j = r_j + 1'b1;
                    o_raddr = AW'(r_j + 1'b1);
                end
            end
            S_SS_SW: begin
                if (r_m != r_i) begin
                    o_we = 1'b1;
                    o_waddr = AW'(r_i);
                    o_wdata = r_key;
                    n_key = i_reg_a;
                    n_sw = cnt_inc(r_sw);
                    n_state = S_WB;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SS_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    n_rsp.compare_count = sat9(r_cmp);
                    n_rsp.swap_count = sat9(r_sw);
                    n_rsp.entry_count = 6'(r_fill);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_sorted <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_sorted <= n_sorted;
            r_ovalid <= n_ovalid;
            r_phase <= n_phase;
        end
        r_req <= n_req;
        r_rsp <= n_rsp;
        r_i <= n_i;
        r_j <= n_j;
        r_m <= n_m;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_cmp <= n_cmp;
        r_sw <= n_sw;
        r_key <= n_key;
    end
endmodule

// ----- design/record_table_sort_search_top.sv -----
// channel | direction | signals
// request | in        | i_req_valid, o_req_ready, i_req (t_req)
// result  | out       | o_rsp_valid, i_rsp_ready, o_rsp (t_rsp)
// One request at a time; one result per request; a held result stalls requests.
// Remove scans entries in order, then shifts later entries down; search is a binary search by name.
// Name sort is a bubble sort of compares and swaps.
// Type sort is an insertion sort (compares and shifts); priority sort is a selection sort.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
module record_table_sort_search_top
    import rts_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    logic          w_we, w_hold_a;
    logic [AW-1:0] w_waddr, w_raddr;
    t_rec          w_wdata, w_rdata, w_reg_a;

    rts_ctrl #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES), .AW(AW), .FW(FW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .o_hold_a    (w_hold_a),
        .i_rdata     (w_rdata),
        .i_reg_a     (w_reg_a)
    );

    rts_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr  (w_raddr),
        .i_hold_a (w_hold_a),
        .o_rdata  (w_rdata),
        .o_reg_a  (w_reg_a)
    );

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !o_req_ready)
        else $error("request ready while result pending");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> int'(o_rsp.entry_count) <= CAPACITY)
        else $error("entry count beyond capacity");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> $stable(o_rsp))
        else $error("result changed while stalled");
`endif
endmodule
